// File: rtl/core/rth_pkg.sv
// Shared types and constants for the RGB to HSV converter.
package rth_pkg;

  localparam int COMPONENT_BITS    = 8;
  localparam int HUE_FRACTION_BITS = 4;

  localparam int FULL_SCALE  = (2 ** COMPONENT_BITS) - 1;
  localparam int DEG_SECTOR  = 60;
  localparam int DEG_FULL    = 360;
  localparam int HUE_SCALE   = DEG_SECTOR * (2 ** HUE_FRACTION_BITS);
  localparam int HUE_LIMIT   = DEG_FULL * (2 ** HUE_FRACTION_BITS);
  localparam int HUE_QUOT_W  = $clog2(HUE_LIMIT);
  localparam int HUE_W       = HUE_QUOT_W + 1;
  localparam int SAT_W       = COMPONENT_BITS;

  // Quotient bits produced by the divider chain; one bit per cell.
  localparam int STEPS  = (HUE_QUOT_W > COMPONENT_BITS) ? HUE_QUOT_W : COMPONENT_BITS;
  // Dividend width seen by the chain: remainder bits above the quotient bits.
  localparam int EXT_W  = STEPS + COMPONENT_BITS;
  // Sector numerator holds up to six times the full scale.
  localparam int NUM_W  = COMPONENT_BITS + 3;

  typedef struct packed {
    logic [COMPONENT_BITS-1:0] red;
    logic [COMPONENT_BITS-1:0] green;
    logic [COMPONENT_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic signed [HUE_W-1:0]   hue;
    logic [SAT_W-1:0]          saturation;
    logic [COMPONENT_BITS-1:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [COMPONENT_BITS-1:0] divisor;
    logic [COMPONENT_BITS-1:0] rem;
    logic [STEPS-1:0]          acc;
  } div_lane_t;

  typedef struct packed {
    logic                      valid;
    logic                      black;
    logic                      gray;
    logic [COMPONENT_BITS-1:0] brightness;
  } cell_ctl_t;

  typedef struct packed {
    cell_ctl_t ctl;
    div_lane_t sat;
    div_lane_t hue;
  } cell_data_t;

endpackage

// File: rtl/core/rgb_to_hsv_top.sv
// Top level of the RGB to HSV converter: front end, divider cell chain, output register.
//
// Usage. A pixel transaction is offered on pixel (red, green, blue) with start
// high; it is taken at any rising edge where start is high and busy is low.
// busy is held low at all times, so a new pixel may be offered on every clock.
// Each result (hue, saturation, brightness) appears on hsv for exactly one
// cycle, flagged by done, and is taken once its pixel has passed through the
// front end registers, each of the thirteen division cells and the output
// register. Results leave in the order the pixels arrived.
// Throughput is one pixel per clock; it is set by the cell chain, where each
// cell resolves one quotient bit of both divisions and hands the partial
// remainders on to its neighbour every cycle.
// The receiver has no way to hold results back, and none is needed: nothing
// in the chain ever waits.
// Reset is synchronous and active high. It clears the valid flags along the
// whole chain, so no stray done pulse follows reset; the data registers are
// not cleared and carry no meaning until a pixel flows through them.
// Black gives hue and saturation of zero; any other grey gives a hue of all
// ones (minus one) with zero saturation.
module rgb_to_hsv_top
  import rth_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  output logic   busy,
  input  pixel_t pixel,
  output logic   done,
  output hsv_t   hsv
);

  // The pipeline never stalls, so transactions are always welcome.
  assign busy = 1'b0;

  // Stage boundaries of the divider chain: entry zero is fed by the front end
  // and entry STEPS holds fully resolved quotients.
  cell_data_t chain [STEPS+1];

  rth_prep u_prep (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .pixel (pixel),
    .lane  (chain[0])
  );

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    rth_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  // Final formatting: the special cases for black and grey override the
  // quotients, which are meaningless there since a divisor is zero.
  cell_data_t tail;
  hsv_t       hsv_next;

  always_comb begin
    tail                = chain[STEPS];
    hsv_next.brightness = tail.ctl.brightness;
    if (tail.ctl.black) begin
      hsv_next.hue        = '0;
      hsv_next.saturation = '0;
    end else if (tail.ctl.gray) begin
      hsv_next.hue        = '1;
      hsv_next.saturation = '0;
    end else begin
      hsv_next.hue        = HUE_W'(tail.hue.acc);
      hsv_next.saturation = SAT_W'(tail.sat.acc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tail.ctl.valid;
    end
    hsv <= hsv_next;
  end

endmodule

// File: rtl/core/rth_prep.sv
// Front end: finds max, min and sector, and forms both divider operands.
module rth_prep
  import rth_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  pixel_t     pixel,
  output cell_data_t lane
);

  typedef enum logic [1:0] {
    MAX_RED,
    MAX_GREEN,
    MAX_BLUE
  } max_sel_t;

  // First stage registers.
  cell_ctl_t                 ctl_a;
  logic [COMPONENT_BITS-1:0] delta_a;
  logic [COMPONENT_BITS-1:0] absdiff_a;
  logic                      pos_ge_a;
  max_sel_t                  which_a;

  logic [COMPONENT_BITS-1:0] mx, mn, pos, neg;
  max_sel_t                  which;

  always_comb begin
    mx    = pixel.red;
    which = MAX_RED;
    if (pixel.green > mx) begin
      mx    = pixel.green;
      which = MAX_GREEN;
    end
    if (pixel.blue > mx) begin
      mx    = pixel.blue;
      which = MAX_BLUE;
    end
    mn = pixel.red;
    if (pixel.green < mn) mn = pixel.green;
    if (pixel.blue < mn)  mn = pixel.blue;
    case (which)
      MAX_RED: begin
        pos = pixel.green;
        neg = pixel.blue;
      end
      MAX_GREEN: begin
        pos = pixel.blue;
        neg = pixel.red;
      end
      MAX_BLUE: begin
        pos = pixel.red;
        neg = pixel.green;
      end
      default: begin
        pos = '0;
        neg = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a.valid <= 1'b0;
    end else begin
      ctl_a.valid <= start;
    end
    ctl_a.black      <= (mx == '0);
    ctl_a.gray       <= (mx == mn) && (mx != '0);
    ctl_a.brightness <= mx;
    delta_a          <= mx - mn;
    pos_ge_a         <= (pos >= neg);
    absdiff_a        <= (pos >= neg) ? (pos - neg) : (neg - pos);
    which_a          <= which;
  end

  // Second stage: sector numerator, then the two dividends.
  logic [NUM_W-1:0] d_ext, sector_term, num;
  logic [EXT_W-1:0] sat_divd, hue_divd;

  always_comb begin
    d_ext = NUM_W'(delta_a);
    case (which_a)
      MAX_RED:   sector_term = pos_ge_a ? '0 : ((d_ext << 2) + (d_ext << 1));
      MAX_GREEN: sector_term = d_ext << 1;
      MAX_BLUE:  sector_term = d_ext << 2;
      default:   sector_term = '0;
    endcase
    num = pos_ge_a ? (sector_term + NUM_W'(absdiff_a))
                   : (sector_term - NUM_W'(absdiff_a));
    sat_divd = (EXT_W'(delta_a) << COMPONENT_BITS) - EXT_W'(delta_a);
    hue_divd = EXT_W'(num) * EXT_W'(HUE_SCALE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane.ctl.valid <= 1'b0;
    end else begin
      lane.ctl.valid <= ctl_a.valid;
    end
    lane.ctl.black      <= ctl_a.black;
    lane.ctl.gray       <= ctl_a.gray;
    lane.ctl.brightness <= ctl_a.brightness;
    lane.sat.divisor    <= ctl_a.brightness;
    lane.sat.rem        <= sat_divd[EXT_W-1:STEPS];
    lane.sat.acc        <= sat_divd[STEPS-1:0];
    lane.hue.divisor    <= delta_a;
    lane.hue.rem        <= hue_divd[EXT_W-1:STEPS];
    lane.hue.acc        <= hue_divd[STEPS-1:0];
  end

endmodule

// File: rtl/core/rth_div_cell.sv
// One restoring division step for the saturation and hue dividers.
module rth_div_cell
  import rth_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_data_t din,
  output cell_data_t dout
);

  logic [COMPONENT_BITS:0] sat_trial, hue_trial;
  logic                    sat_ge, hue_ge;
  div_lane_t               sat_next, hue_next;

  always_comb begin
    sat_trial = {din.sat.rem, din.sat.acc[STEPS-1]};
    hue_trial = {din.hue.rem, din.hue.acc[STEPS-1]};
    sat_ge    = (sat_trial >= {1'b0, din.sat.divisor});
    hue_ge    = (hue_trial >= {1'b0, din.hue.divisor});

    sat_next.divisor = din.sat.divisor;
    sat_next.rem     = sat_ge ? COMPONENT_BITS'(sat_trial - {1'b0, din.sat.divisor})
                              : COMPONENT_BITS'(sat_trial);
    sat_next.acc     = {din.sat.acc[STEPS-2:0], sat_ge};

    hue_next.divisor = din.hue.divisor;
    hue_next.rem     = hue_ge ? COMPONENT_BITS'(hue_trial - {1'b0, din.hue.divisor})
                              : COMPONENT_BITS'(hue_trial);
    hue_next.acc     = {din.hue.acc[STEPS-2:0], hue_ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.ctl.valid <= 1'b0;
    end else begin
      dout.ctl.valid <= din.ctl.valid;
    end
    dout.ctl.black      <= din.ctl.black;
    dout.ctl.gray       <= din.ctl.gray;
    dout.ctl.brightness <= din.ctl.brightness;
    dout.sat            <= sat_next;
    dout.hue            <= hue_next;
  end

endmodule
